/* hdl/douq_pkg.sv */
// shared types and constants for the date ordered unique queue
`timescale 1ns / 1ps
`default_nettype none
package douq_pkg;
   localparam int QUEUE_DEPTH = 32;
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int KEY_W = 9;
   localparam int IDENT_W = 35;
   localparam int DESC_W = 32;
   localparam int ENTRY_W = KEY_W + IDENT_W + DESC_W;
   localparam int REQ_W = 96;
   localparam int RSP_W = 88;
   localparam logic [2:0] NO_COURSE = 3'd6;
   localparam logic [2:0] MAX_COURSE = 3'd5;

   typedef enum logic [1:0] {
      ACT_ENQ = 2'd0,
      ACT_DEQ = 2'd1,
      ACT_DUE = 2'd2,
      ACT_LIST = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_REJECT = 2'd1,
      ST_NONE = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_MONTH = 1'd0,
      CSR_DAY = 1'd1
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_WAIT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [IDENT_W-1:0] ident;
      logic [DESC_W-1:0] desc;
   } entry_type;

   // days-left unit command
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [3:0] cur_month;
      logic [4:0] cur_day;
   } calc_req_type;
endpackage
`default_nettype wire

/* hdl/douq_days.sv */
// shared days-left unit: thirty-day month arithmetic on a stored key
`timescale 1ns / 1ps
`default_nettype none
module douq_days
   import douq_pkg::*;
(
   input wire logic clock,
   input wire calc_req_type req,
   output logic signed [9:0] days_ff
);
   logic signed [9:0] days_in;
   logic [8:0] due, now;
   always_comb begin
      due = 9'(req.key[8:5]) * 9'd30 + 9'(req.key[4:0]);
      now = 9'(req.cur_month) * 9'd30 + 9'(req.cur_day);
      days_in = 10'($signed({1'b0, due}) - $signed({1'b0, now}));
   end
   always_ff @(posedge clock) begin
      days_ff <= days_in;
   end
endmodule
`default_nettype wire

/* hdl/douq_store.sv */
// entry memory, one read and one write port
`timescale 1ns / 1ps
`default_nettype none
module douq_store
   import douq_pkg::*;
(
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [IDX_W-1:0] wr_addr,
   input wire entry_type wr_data,
   input wire logic [IDX_W-1:0] rd_addr,
   output entry_type rd_data_ff
);
   entry_type mem [QUEUE_DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hdl/date_ordered_unique_queue.sv */
// top level of the date ordered unique queue
//  channel | dir | handshake        | payload
//  req     | in  | tvalid/tready    | tdata: action..num_days (90 bits, zero fill to 96)
//  rsp     | out | tvalid/tready    | tdata: status..days_left (88 bits), tlast: last
//  csr     | in  | wr_en            | 0 current_month, 1 current_day
// a transaction walks the stored entries in turn through the single memory read port
// the read port and shared days-left unit pace the walk; req_tready is low meanwhile
// reset (synchronous) empties the queue and sets today to month 1 day 1
// a stalled rsp holds the list walk in place
`timescale 1ns / 1ps
`default_nettype none
module date_ordered_unique_queue
   import douq_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // action, course, assign_number, due_month, due_day, desc_handle, num_days
   input wire logic [REQ_W-1:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // status, course_out, assign_number_out, due_month_out, due_day_out,
   // desc_handle_out, days_left
   output logic [RSP_W-1:0] rsp_tdata,
   output logic rsp_tlast,
   input wire logic csr_wr_en,
   input wire logic [0:0] csr_index,
   input wire logic [4:0] csr_wdata
);
   state_type state_ff, state_in;
   logic [3:0] month_ff;
   logic [4:0] day_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;     // scan / shift pointer
   logic [CNT_W-1:0] pos_ff, pos_in;     // insert or hit position
   logic found_ff, found_in;            // insert position or hit found
   logic dup_ff, dup_in;
   logic [1:0] act_ff;
   logic [2:0] course_ff;
   logic [31:0] num_ff;
   logic [8:0] key_ff;
   logic [31:0] desc_ff;
   logic signed [10:0] nd_ff;
   logic rd_pend_ff, rd_pend_in;        // read data of rd_idx arrives this cycle
   logic [CNT_W-1:0] rd_idx_ff;
   logic rv_ff, rv_in, rl_ff, rl_in;
   logic [RSP_W-1:0] rd_ff, rd_in;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_q;
   logic signed [9:0] days;
   calc_req_type creq;

   douq_store u_store (.clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data_ff(rd_q));
   douq_days u_days (.clock, .req(creq), .days_ff(days));
   assign creq = '{key: rd_q.key, cur_month: month_ff, cur_day: day_ff};

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;
   assign rsp_tlast = rl_ff;

   function automatic logic [RSP_W-1:0] pack(status_type s, entry_type e, logic hit,
                                              logic signed [9:0] dl);
      logic [RSP_W-1:0] r;
      r = '0;
      r[1:0] = s;
      r[4:2] = NO_COURSE;
      if (hit) begin
         r[4:2] = e.ident[34:32];
         r[36:5] = e.ident[31:0];
         r[40:37] = e.key[8:5];
         r[45:41] = e.key[4:0];
         r[77:46] = e.desc;
         r[87:78] = dl;
      end
      return r;
   endfunction

   logic [CNT_W-1:0] ridx;
   entry_type newe;
   always_comb begin
      newe = '{key: key_ff, ident: {course_ff, num_ff}, desc: desc_ff};
   end

   // entry whose read data is present this cycle
   assign ridx = rd_idx_ff;
   entry_type e_dly;
   logic hit_dly, dly_valid;

   // signed window compare for the list
   logic keep;
   assign keep = $signed({days[9], days}) <= nd_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      found_in = found_ff;
      dup_in = dup_ff;
      rd_pend_in = 1'b0;
      rv_in = rv_ff;
      rl_in = rl_ff;
      rd_in = rd_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff[IDX_W-1:0];
      wr_data = newe;
      rd_addr = idx_ff[IDX_W-1:0];
      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               idx_in = '0;
               found_in = 1'b0;
               dup_in = 1'b0;
               pos_in = count_ff;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue reads of idx, examine data of rd_idx
            if (rd_pend_ff) begin
               unique case (action_type'(act_ff))
                  ACT_ENQ: begin
                     if (rd_q.ident == {course_ff, num_ff}) dup_in = 1'b1;
                     if (!found_ff && key_ff < rd_q.key) begin
                        found_in = 1'b1;
                        pos_in = ridx;
                     end
                  end
                  ACT_DUE: begin
                     if (!found_ff && rd_q.ident[34:32] == course_ff) begin
                        found_in = 1'b1;
                        pos_in = ridx;
                     end
                  end
                  default: ;
               endcase
            end
            if (idx_ff < count_ff && !(act_ff == ACT_DEQ)) begin
               rd_pend_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else if (!rd_pend_ff || act_ff == ACT_DEQ) begin
               idx_in = count_ff;
               state_in = S_SHIFT;
               if (act_ff == ACT_DEQ) idx_in = '0;
               if (act_ff == ACT_LIST) begin
                  idx_in = '0;
                  state_in = S_EMIT;
               end
               if (act_ff == ACT_DUE) begin
                  idx_in = pos_ff;
                  state_in = S_WAIT;
               end
            end
         end
         S_SHIFT: begin
            // enqueue: reject or move entries up from the tail; dequeue: read head then move down
            if (act_ff == ACT_ENQ) begin
               if (dup_ff || count_ff >= CNT_W'(QUEUE_DEPTH) || key_ff[4:0] == 0
                   || key_ff[8:5] == 0 || key_ff[8:5] > 4'd12 || course_ff > MAX_COURSE
                   || desc_ff == '0) begin
                  if (!rv_ff) begin
                     rv_in = 1'b1; rl_in = 1'b1;
                     rd_in = pack(ST_REJECT, newe, 1'b0, '0);
                     state_in = S_IDLE;
                  end
               end else if (rd_pend_ff) begin
                  wr_en = 1'b1;
                  wr_addr = ridx[IDX_W-1:0] + 1'b1;
                  wr_data = rd_q;
               end
               if (!(dup_ff || count_ff >= CNT_W'(QUEUE_DEPTH) || key_ff[4:0] == 0
                   || key_ff[8:5] == 0 || key_ff[8:5] > 4'd12 || course_ff > MAX_COURSE
                   || desc_ff == '0)) begin
                  if (idx_ff > pos_ff) begin
                     rd_addr = IDX_W'(idx_ff - 1'b1);
                     rd_pend_in = 1'b1;
                     idx_in = idx_ff - 1'b1;
                  end else if (!rd_pend_ff && !rv_ff) begin
                     wr_en = 1'b1;
                     wr_addr = pos_ff[IDX_W-1:0];
                     wr_data = newe;
                     count_in = count_ff + 1'b1;
                     rv_in = 1'b1; rl_in = 1'b1;
                     rd_in = pack(ST_OK, newe, 1'b0, '0);
                     state_in = S_IDLE;
                  end
               end
            end else begin
               if (count_ff == '0) begin
                  if (!rv_ff) begin
                     rv_in = 1'b1; rl_in = 1'b1;
                     rd_in = pack(ST_NONE, newe, 1'b0, '0);
                     state_in = S_IDLE;
                  end
               end else begin
                  if (rd_pend_ff) begin
                     if (ridx == '0) begin
                        rv_in = 1'b1; rl_in = 1'b1;
                        rd_in = pack(ST_OK, rd_q, 1'b1, '0);
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = IDX_W'(ridx - 1'b1);
                        wr_data = rd_q;
                     end
                  end
                  if (idx_ff < count_ff && !(rv_ff && idx_ff == '0)) begin
                     rd_pend_in = 1'b1;
                     idx_in = idx_ff + 1'b1;
                  end else if (!rd_pend_ff && idx_ff == count_ff) begin
                     count_in = count_ff - 1'b1;
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_WAIT: begin
            // days till due: no hit replies none, else read hit, then days unit, then reply
            if (!found_ff) begin
               if (!rv_ff) begin
                  rv_in = 1'b1; rl_in = 1'b1;
                  rd_in = pack(ST_NONE, newe, 1'b0, '0);
                  state_in = S_IDLE;
               end
            end else if (dly_valid && !rv_ff) begin
               rv_in = 1'b1; rl_in = 1'b1;
               rd_in = pack(ST_OK, e_dly, 1'b1, days);
               state_in = S_IDLE;
            end else if (!rd_pend_ff && !hit_dly && !dly_valid) begin
               rd_addr = pos_ff[IDX_W-1:0];
               rd_pend_in = 1'b1;
            end
         end
         S_EMIT: begin
            // list: read, compute days, compare, emit each kept entry when rsp is free
            if (dly_valid && !rv_ff) begin
               if (hit_dly && keep) begin
                  rv_in = 1'b1; rl_in = 1'b0;
                  rd_in = pack(ST_OK, e_dly, 1'b1, days);
               end
            end
            if (nd_ff < 0 || (idx_ff >= count_ff && !rd_pend_ff && !dly_valid)) begin
               if (!rv_in && !rv_ff) begin
                  rv_in = 1'b1; rl_in = 1'b1;
                  rd_in = pack(ST_NONE, newe, 1'b0, '0);
                  state_in = S_IDLE;
               end
            end else if (idx_ff < count_ff && !rd_pend_ff && !dly_valid && !rv_ff) begin
               rd_pend_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // one stage after read data: days unit output lines up with the entry
   always_ff @(posedge clock) begin
      e_dly <= rd_q;
      if (reset) begin
         dly_valid <= 1'b0;
         hit_dly <= 1'b0;
      end else begin
         if ((state_ff == S_EMIT || state_ff == S_WAIT) && rd_pend_ff) begin
            dly_valid <= 1'b1;
            hit_dly <= 1'b1;
         end else if (dly_valid && !rv_ff) begin
            dly_valid <= 1'b0;
            hit_dly <= state_ff == S_WAIT;
         end else if (state_ff == S_IDLE) begin
            hit_dly <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         month_ff <= 4'd1;
         day_ff <= 5'd1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff <= rv_in;
         rd_pend_ff <= rd_pend_in;
         if (csr_wr_en) begin
            unique case (csr_type'(csr_index))
               CSR_MONTH: month_ff <= csr_wdata[3:0];
               CSR_DAY: day_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      found_ff <= found_in;
      dup_ff <= dup_in;
      rd_ff <= rd_in;
      rl_ff <= rl_in;
      rd_idx_ff <= rd_pend_in ? ((state_ff == S_WAIT) ? pos_ff
                   : (state_ff == S_SHIFT && act_ff == ACT_ENQ) ? idx_ff - 1'b1 : idx_ff)
                   : rd_idx_ff;
      if (req_tvalid && req_tready) begin
         act_ff <= req_tdata[1:0];
         course_ff <= req_tdata[4:2];
         num_ff <= req_tdata[36:5];
         key_ff <= {req_tdata[40:37], (req_tdata[46:41] > 6'd31) ? 5'd0 : req_tdata[45:41]};
         desc_ff <= req_tdata[78:47];
         nd_ff <= req_tdata[89:79];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH)) else $error("count overflow");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready while busy");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid) else $error("result after last");
endmodule
`default_nettype wire
